// File: hdl/i2ct_pkg.sv
`default_nettype none

package i2ct_pkg;

    // Request type codes
    typedef logic [1:0] req_type_t;
    localparam req_type_t REQ_WRITE = 2'd0;
    localparam req_type_t REQ_PTR   = 2'd1;
    localparam req_type_t REQ_READ  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd1;

    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd1;

    // Bus phases
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START_A  = 5'd1,
        PH_START_B  = 5'd2,
        PH_START_C  = 5'd3,
        PH_TX_LOW   = 5'd4,
        PH_TX_HIGH  = 5'd5,
        PH_ACK_LOW  = 5'd6,
        PH_ACK_HIGH = 5'd7,
        PH_ACK_POLL = 5'd8,
        PH_RX_HIGH  = 5'd9,
        PH_RX_LOW   = 5'd10,
        PH_MACK_A   = 5'd11,
        PH_MACK_B   = 5'd12,
        PH_MACK_C   = 5'd13,
        PH_STOP_A   = 5'd14,
        PH_STOP_B   = 5'd15,
        PH_STOP_C   = 5'd16
    } phase_t;

    // One classified tick, as held in the queue
    typedef struct packed {
        logic       req_ok;    // request present and of a known type
        req_type_t  req_type;
        logic [7:0] dev_addr;
        logic [7:0] reg_pointer;
        logic [15:0] write_data;
        logic       sda_in;
    } tick_t;

    // One result
    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        busy;
        logic        done;
        logic [15:0] read_data;
        logic        ack_error;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/i2ct_front.sv
`default_nettype none

module i2ct_front
    import i2ct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_valid,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  dev_addr,
    input  wire logic [7:0]  reg_pointer,
    input  wire logic [15:0] write_data,
    input  wire logic        sda_in,
    output logic             q_valid,
    output tick_t            q_tick,
    input  wire logic        q_pop
);

    // two-entry queue between front and engine
    tick_t      mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    tick_t      cls;

    always_comb
    begin
        cls.req_ok      = req_valid && (req_type == REQ_WRITE || req_type == REQ_PTR ||
                                        req_type == REQ_READ);
        cls.req_type    = req_type;
        cls.dev_addr    = dev_addr;
        cls.reg_pointer = reg_pointer;
        cls.write_data  = write_data;
        cls.sda_in      = sda_in;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_tick   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/i2ct_engine.sv
`default_nettype none

module i2ct_engine
    import i2ct_pkg::*;
#(
    parameter int DATA_BYTES = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 q_valid,
    input  wire tick_t                q_tick,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output res_t                      res
);

    localparam int IDX_W = $clog2(DATA_BYTES + 3);
    localparam logic [IDX_W-1:0] CNT_WRITE = IDX_W'(DATA_BYTES + 2);
    localparam logic [IDX_W-1:0] CNT_PTR   = IDX_W'(2);
    localparam logic [IDX_W-1:0] CNT_READ  = IDX_W'(1);
    localparam logic [IDX_W-1:0] LAST_RX   = IDX_W'(DATA_BYTES);

    function automatic logic [7:0] tx_byte(input logic [IDX_W-1:0] idx,
                                           input req_type_t rtype,
                                           input logic [7:0] addr,
                                           input logic [7:0] rptr,
                                           input logic [15:0] data);
        logic [IDX_W-1:0] pos;
        logic [7:0]       b;
        pos = IDX_W'(DATA_BYTES + 1) - idx;
        b   = 8'h00;
        if (idx == '0)
            b = (rtype == REQ_READ) ? addr + 8'd1 : addr;
        else if (idx == IDX_W'(1))
            b = rptr;
        else if (idx < CNT_WRITE)
        begin
            if (pos == '0)
                b = data[7:0];
            else if (pos == IDX_W'(1))
                b = data[15:8];
        end
        return b;
    endfunction

    // configuration
    logic [7:0]  timeout_reg;
    logic [15:0] phase_ticks_reg;

    // transaction state
    phase_t           state_reg, state_next;
    logic [15:0]      timer_reg, timer_next;
    logic [3:0]       bit_reg, bit_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       shift_reg, shift_next;
    logic [15:0]      acc_reg, acc_next;
    logic [7:0]       poll_reg, poll_next;
    req_type_t        type_reg, type_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       ptr_reg, ptr_next;
    logic [15:0]      data_reg, data_next;
    logic             err_reg, err_next;

    // output stage
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    // state as seen after an optional request latch
    phase_t           cur_state;
    logic [15:0]      cur_timer;
    logic [3:0]       cur_bit;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] tx_cnt;
    logic [15:0]      phase_len;
    logic             phase_end;
    logic             ackbit;
    logic             adv;
    logic [3:0]       bit_inc;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        cur_state  = state_reg;
        cur_timer  = timer_reg;
        cur_bit    = bit_reg;
        cur_idx    = idx_reg;
        shift_next = shift_reg;
        acc_next   = acc_reg;
        poll_next  = poll_reg;
        type_next  = type_reg;
        addr_next  = addr_reg;
        ptr_next   = ptr_reg;
        data_next  = data_reg;
        err_next   = err_reg;

        // a request on an idle tick starts the transaction on that tick
        if (state_reg == PH_IDLE && q_tick.req_ok)
        begin
            cur_state  = PH_START_A;
            cur_timer  = 16'd0;
            cur_bit    = 4'd0;
            cur_idx    = '0;
            shift_next = 8'd0;
            acc_next   = 16'd0;
            poll_next  = 8'd0;
            type_next  = q_tick.req_type;
            addr_next  = q_tick.dev_addr;
            ptr_next   = q_tick.reg_pointer;
            data_next  = q_tick.write_data;
            err_next   = 1'b0;
        end

        phase_len = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
        phase_end = ({1'b0, cur_timer} + 17'd1) >= {1'b0, phase_len};
        ackbit    = (cur_idx >= LAST_RX);
        idx_inc   = cur_idx + IDX_W'(1);
        bit_inc   = cur_bit + 4'd1;

        case (type_next)
            REQ_WRITE: tx_cnt = CNT_WRITE;
            REQ_PTR:   tx_cnt = CNT_PTR;
            default:   tx_cnt = CNT_READ;
        endcase

        state_next        = cur_state;
        bit_next          = cur_bit;
        idx_next          = cur_idx;
        adv               = 1'b0;
        res_next.scl_level = 1'b1;
        res_next.sda_level = 1'b1;
        res_next.done      = 1'b0;
        res_next.read_data = 16'd0;
        res_next.ack_error = 1'b0;

        case (cur_state)
            PH_START_A:
            begin
                if (phase_end)
                begin
                    state_next = PH_START_B;
                    adv = 1'b1;
                end
            end
            PH_START_B:
            begin
                res_next.sda_level = 1'b0;
                if (phase_end)
                begin
                    state_next = PH_START_C;
                    adv = 1'b1;
                end
            end
            PH_START_C:
            begin
                res_next.scl_level = 1'b0;
                res_next.sda_level = 1'b0;
                if (phase_end)
                begin
                    shift_next = tx_byte(cur_idx, type_next, addr_next, ptr_next, data_next);
                    bit_next   = 4'd0;
                    state_next = PH_TX_LOW;
                    adv = 1'b1;
                end
            end
            PH_TX_LOW:
            begin
                res_next.scl_level = 1'b0;
                res_next.sda_level = shift_next[7];
                if (phase_end)
                begin
                    state_next = PH_TX_HIGH;
                    adv = 1'b1;
                end
            end
            PH_TX_HIGH:
            begin
                res_next.sda_level = shift_next[7];
                if (phase_end)
                begin
                    shift_next = {shift_next[6:0], 1'b0};
                    if (bit_inc >= 4'd8)
                    begin
                        bit_next   = 4'd0;
                        state_next = PH_ACK_LOW;
                    end
                    else
                    begin
                        bit_next   = bit_inc;
                        state_next = PH_TX_LOW;
                    end
                    adv = 1'b1;
                end
            end
            PH_ACK_LOW:
            begin
                res_next.scl_level = 1'b0;
                if (phase_end)
                begin
                    state_next = PH_ACK_HIGH;
                    adv = 1'b1;
                end
            end
            PH_ACK_HIGH:
            begin
                if (phase_end)
                begin
                    poll_next  = 8'd0;
                    state_next = PH_ACK_POLL;
                    adv = 1'b1;
                end
            end
            PH_ACK_POLL:
            begin
                // one poll per tick, no phase timing
                adv = 1'b1;
                if (!q_tick.sda_in)
                begin
                    idx_next = idx_inc;
                    if (idx_inc < tx_cnt)
                    begin
                        shift_next = tx_byte(idx_inc, type_next, addr_next, ptr_next,
                                             data_next);
                        bit_next   = 4'd0;
                        state_next = PH_TX_LOW;
                    end
                    else if (type_next == REQ_READ)
                    begin
                        bit_next   = 4'd0;
                        state_next = PH_RX_HIGH;
                    end
                    else
                    begin
                        state_next = PH_STOP_A;
                    end
                end
                else if (poll_next >= timeout_reg)
                begin
                    err_next   = 1'b1;
                    state_next = PH_STOP_A;
                end
                else
                begin
                    poll_next = poll_next + 8'd1;
                end
            end
            PH_RX_HIGH:
            begin
                if (phase_end)
                begin
                    acc_next   = {acc_next[14:0], q_tick.sda_in};
                    bit_next   = bit_inc;
                    state_next = PH_RX_LOW;
                    adv = 1'b1;
                end
            end
            PH_RX_LOW:
            begin
                res_next.scl_level = 1'b0;
                if (phase_end)
                begin
                    if (cur_bit >= 4'd8)
                    begin
                        bit_next   = 4'd0;
                        state_next = PH_MACK_A;
                    end
                    else
                    begin
                        state_next = PH_RX_HIGH;
                    end
                    adv = 1'b1;
                end
            end
            PH_MACK_A:
            begin
                res_next.scl_level = 1'b0;
                res_next.sda_level = ackbit;
                if (phase_end)
                begin
                    state_next = PH_MACK_B;
                    adv = 1'b1;
                end
            end
            PH_MACK_B:
            begin
                res_next.sda_level = ackbit;
                if (phase_end)
                begin
                    state_next = PH_MACK_C;
                    adv = 1'b1;
                end
            end
            PH_MACK_C:
            begin
                res_next.scl_level = 1'b0;
                res_next.sda_level = ackbit;
                if (phase_end)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc > LAST_RX) ? PH_STOP_A : PH_RX_HIGH;
                    adv = 1'b1;
                end
            end
            PH_STOP_A:
            begin
                res_next.scl_level = 1'b0;
                res_next.sda_level = 1'b0;
                if (phase_end)
                begin
                    state_next = PH_STOP_B;
                    adv = 1'b1;
                end
            end
            PH_STOP_B:
            begin
                res_next.sda_level = 1'b0;
                if (phase_end)
                begin
                    state_next = PH_STOP_C;
                    adv = 1'b1;
                end
            end
            PH_STOP_C:
            begin
                if (phase_end)
                begin
                    res_next.done      = 1'b1;
                    res_next.ack_error = err_next;
                    res_next.read_data = (type_next == REQ_READ) ? acc_next : 16'd0;
                    state_next = PH_IDLE;
                    adv = 1'b1;
                end
            end
            default:
            begin
                state_next = PH_IDLE;
                adv = 1'b1;
            end
        endcase

        timer_next    = adv ? 16'd0 : cur_timer + 16'd1;
        res_next.busy = (state_next != PH_IDLE);

        if (q_pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= ACK_TIMEOUT_RST;
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ACK_TIMEOUT: timeout_reg     <= cfg_wdata[7:0];
                CFG_PHASE_TICKS: phase_ticks_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_IDLE;
            timer_reg     <= 16'd0;
            bit_reg       <= 4'd0;
            idx_reg       <= '0;
            shift_reg     <= 8'd0;
            acc_reg       <= 16'd0;
            poll_reg      <= 8'd0;
            type_reg      <= REQ_WRITE;
            addr_reg      <= 8'd0;
            ptr_reg       <= 8'd0;
            data_reg      <= 16'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                state_reg <= state_next;
                timer_reg <= timer_next;
                bit_reg   <= bit_next;
                idx_reg   <= idx_next;
                shift_reg <= shift_next;
                acc_reg   <= acc_next;
                poll_reg  <= poll_next;
                type_reg  <= type_next;
                addr_reg  <= addr_next;
                ptr_reg   <= ptr_next;
                data_reg  <= data_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done) |-> !res_reg.busy)
        else $error("done reported while still busy");

    a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.ack_error) |-> res_reg.done)
        else $error("ack_error without done");

    a_idle_lines_released: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && state_reg == PH_IDLE && !q_tick.req_ok) |=>
            (res_reg.scl_level && res_reg.sda_level && !res_reg.busy))
        else $error("idle tick did not release the bus");
`endif

endmodule

`default_nettype wire

// File: hdl/i2c_register_transaction_master.sv
// I2C register transaction master, one bus tick per transaction.
//
// Input channel (in_valid/in_ready): every transaction is one bus tick with
// the sampled SDA level and, optionally, a request (write, pointer set, or
// two-byte read). Requests seen while a bus transfer is running are ignored.
// Output channel (out_valid/out_ready): exactly one result per input tick
// with the driven SCL/SDA levels, busy, a done pulse, read data and the ack
// timeout flag (the last two only meaningful with done).
// Config port: cfg_write_en/cfg_index/cfg_wdata, index 0 = ack timeout
// polls, 1 = ticks per SCL/SDA phase. Write only while idle.
// A tick is written into the queue at the accepting edge and its result is
// then registered in the output register, from which it is presented.
// Throughput: one tick per cycle while out_ready holds, set by the bit
// engine updating once per tick.
// Reset: engine idle, queue empty, config back to 250 polls
// and 1 tick per phase.
// Stall: when out_ready is low the result holds, the two-entry tick queue
// fills and in_ready drops; no tick is lost.
`default_nettype none

module i2c_register_transaction_master
    import i2ct_pkg::*;
#(
    parameter int DATA_BYTES = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_wdata,
    // tick input
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 req_valid,
    input  wire logic [1:0]           req_type,
    input  wire logic [7:0]           dev_addr,
    input  wire logic [7:0]           reg_pointer,
    input  wire logic [15:0]          write_data,
    input  wire logic                 sda_in,
    // results
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      scl_level,
    output logic                      sda_level,
    output logic                      busy_res,
    output logic                      done_res,
    output logic [15:0]               read_data,
    output logic                      ack_error
);

    logic  q_valid;
    logic  q_pop;
    tick_t q_tick;
    res_t  res;

    // front: classify request, buffer ticks
    i2ct_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_valid   (req_valid),
        .req_type    (req_type),
        .dev_addr    (dev_addr),
        .reg_pointer (reg_pointer),
        .write_data  (write_data),
        .sda_in      (sda_in),
        .q_valid     (q_valid),
        .q_tick      (q_tick),
        .q_pop       (q_pop)
    );

    // back: bus phase sequencer and result register
    i2ct_engine #(
        .DATA_BYTES (DATA_BYTES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_valid      (q_valid),
        .q_tick       (q_tick),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .res          (res)
    );

    assign scl_level = res.scl_level;
    assign sda_level = res.sda_level;
    assign busy_res  = res.busy;
    assign done_res  = res.done;
    assign read_data = res.read_data;
    assign ack_error = res.ack_error;

endmodule

`default_nettype wire
